// ===== hw/rtl/stic_pkg.sv =====
// ----------------------------------------------------------------------------
// stic_pkg: shared types and constants for the score table insert core
// Row layout, controller/datapath command and status bundles, op codes.
// ----------------------------------------------------------------------------
package stic_pkg;

    localparam int FUNC_W    = 2;
    localparam int NAME_W    = 24;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 4;
    localparam int INDEX_W   = 4;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;

    // operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // one table row, name byte 0 in the low bits
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [VAL_W-1:0]  extra;
        logic [VAL_W-1:0]  score;
    } row_t;

    // one result item
    typedef struct packed {
        row_t             row;
        logic [POS_W-1:0] pos;
        logic             inserted;
        logic             name_free;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic             req_load;
        logic             rd_en;
        logic             rd_use_index;
        logic             wr_en;
        logic             wr_new;
        logic             res_set;
        logic             res_free;
        logic             res_ins;
        logic             res_row;
        logic [POS_W-1:0] res_pos;
        logic             out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              name_match;
        logic              score_less;
    } status_t;

endpackage

// ===== hw/rtl/stic_dp.sv =====
// ----------------------------------------------------------------------------
// stic_dp: score table datapath
// Request registers, row memory with per-row valid bits, compare logic,
// pending result and output register.
// ----------------------------------------------------------------------------
module stic_dp #(
    parameter int RANKED_ROWS = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request fields
    input  logic [stic_pkg::FUNC_W-1:0]   req_func,
    input  logic [stic_pkg::NAME_W-1:0]   req_name,
    input  logic [stic_pkg::VAL_W-1:0]    req_extra,
    input  logic [stic_pkg::VAL_W-1:0]    req_score,
    input  logic [stic_pkg::INDEX_W-1:0]  req_index,
    // controller interface
    input  stic_pkg::cmd_t                cmd,
    input  logic [$clog2(RANKED_ROWS+1)-1:0] rd_addr,
    input  logic [$clog2(RANKED_ROWS+1)-1:0] wr_addr,
    output stic_pkg::status_t             st,
    // output register
    output stic_pkg::res_t                out_res
);

    localparam int ROWS = RANKED_ROWS + 1;
    localparam int AW   = $clog2(ROWS);

    logic [stic_pkg::FUNC_W-1:0]  func_reg;
    logic [stic_pkg::NAME_W-1:0]  name_reg;
    logic [stic_pkg::VAL_W-1:0]   extra_reg;
    logic [stic_pkg::VAL_W-1:0]   score_reg;
    logic [stic_pkg::INDEX_W-1:0] index_reg;

    stic_pkg::row_t mem [ROWS];
    logic [ROWS-1:0] valid_reg;

    stic_pkg::row_t rd_data_reg;
    logic           rd_valid_reg;
    logic           rd_range_reg;

    stic_pkg::row_t row_eff;
    stic_pkg::row_t new_row;
    stic_pkg::res_t pend_reg;
    stic_pkg::res_t out_reg;

    logic          idx_in_range;
    logic [AW-1:0] rd_addr_eff;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            func_reg  <= req_func;
            name_reg  <= req_name;
            extra_reg <= req_extra;
            score_reg <= req_score;
            index_reg <= req_index;
        end
    end

    // read address: walk counter or requested row
    assign idx_in_range = 32'(index_reg) <= 32'(RANKED_ROWS);
    assign rd_addr_eff  = cmd.rd_use_index ? (idx_in_range ? AW'(index_reg) : '0) : rd_addr;

    // memory read port, registered
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[rd_addr_eff];
            rd_valid_reg <= valid_reg[rd_addr_eff];
            rd_range_reg <= cmd.rd_use_index ? idx_in_range : 1'b1;
        end
    end

    // never-written rows and out-of-range reads look like zero
    assign row_eff = (rd_valid_reg && rd_range_reg) ? rd_data_reg : '0;
    assign new_row = '{name: name_reg, extra: extra_reg, score: score_reg};

    // memory write port: shift a row down or place the new entry
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= cmd.wr_new ? new_row : row_eff;
        end
    end

    // row valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // compare status
    assign st.func       = func_reg;
    assign st.name_match = row_eff.name == name_reg;
    assign st.score_less = $signed(row_eff.score) < $signed(score_reg);

    // pending result
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            pend_reg.name_free <= cmd.res_free;
            pend_reg.inserted  <= cmd.res_ins;
            pend_reg.pos       <= cmd.res_pos;
            pend_reg.row       <= cmd.res_row ? row_eff : '0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= pend_reg;
        end
    end

    assign out_res = out_reg;

endmodule

// ===== hw/rtl/stic_ctrl.sv =====
// ----------------------------------------------------------------------------
// stic_ctrl: score table controller
// Walks the ranked rows bottom-up with a one-row read prefetch, issues
// shift and place writes, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module stic_ctrl #(
    parameter int RANKED_ROWS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  stic_pkg::status_t                st,
    output stic_pkg::cmd_t                   cmd,
    output logic [$clog2(RANKED_ROWS+1)-1:0] rd_addr,
    output logic [$clog2(RANKED_ROWS+1)-1:0] wr_addr
);

    localparam int AW = $clog2(RANKED_ROWS + 1);
    localparam logic [AW-1:0] LAST_RANKED = AW'(RANKED_ROWS - 1);
    localparam logic [stic_pkg::POS_W-1:0] POS_NONE = stic_pkg::POS_W'(RANKED_ROWS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] cr_reg, cr_next;
    logic          iss_reg, iss_next;
    logic          pv_reg, pv_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            cr_reg       <= '0;
            iss_reg      <= 1'b0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            cr_reg       <= cr_next;
            iss_reg      <= iss_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign rd_addr = k_reg;
    assign wr_addr = (state_reg == S_LAST) ? '0 : AW'(cr_reg + AW'(1));

    // next state and commands
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cr_next    = cr_reg;
        iss_next   = iss_reg;
        pv_next    = 1'b0;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.res_pos = POS_NONE;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    k_next       = LAST_RANKED;
                    iss_next     = 1'b1;
                    state_next   = S_RUN;
                end
            end

            S_RUN: begin
                // prefetch the next row
                if (iss_reg) begin
                    cmd.rd_en        = 1'b1;
                    cmd.rd_use_index = st.func == stic_pkg::FUNC_READ;
                    pv_next          = 1'b1;
                    cr_next          = k_reg;
                    if (st.func == stic_pkg::FUNC_READ || k_reg == '0) begin
                        iss_next = 1'b0;
                    end else begin
                        k_next = k_reg - AW'(1);
                    end
                end

                // evaluate the row read last cycle
                case (st.func)
                    stic_pkg::FUNC_READ: begin
                        if (pv_reg) begin
                            cmd.res_set = 1'b1;
                            cmd.res_row = 1'b1;
                            state_next  = S_OUT;
                        end
                    end
                    stic_pkg::FUNC_QUERY: begin
                        if (pv_reg) begin
                            if (st.name_match) begin
                                cmd.res_set = 1'b1;
                                state_next  = S_OUT;
                            end else if (cr_reg == '0) begin
                                cmd.res_set  = 1'b1;
                                cmd.res_free = 1'b1;
                                state_next   = S_OUT;
                            end
                        end
                    end
                    stic_pkg::FUNC_INSERT: begin
                        if (pv_reg) begin
                            if (st.score_less) begin
                                // move this row down one place
                                cmd.wr_en = 1'b1;
                                if (cr_reg == '0) begin
                                    state_next = S_LAST;
                                end
                            end else if (cr_reg == LAST_RANKED) begin
                                cmd.res_set = 1'b1;
                                state_next  = S_OUT;
                            end else begin
                                // new entry goes just below this row
                                cmd.wr_en   = 1'b1;
                                cmd.wr_new  = 1'b1;
                                cmd.res_set = 1'b1;
                                cmd.res_ins = 1'b1;
                                cmd.res_pos = stic_pkg::POS_W'(wr_addr);
                                state_next  = S_OUT;
                            end
                        end
                    end
                    default: begin
                        // unused code: fixed result, table untouched
                        cmd.rd_en   = 1'b0;
                        cmd.res_set = 1'b1;
                        state_next  = S_OUT;
                    end
                endcase

                if (state_next != S_RUN) begin
                    iss_next = 1'b0;
                    pv_next  = 1'b0;
                end
            end

            S_LAST: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.res_set = 1'b1;
                cmd.res_ins = 1'b1;
                cmd.res_pos = '0;
                state_next  = S_OUT;
            end

            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hw/rtl/top_score_table_insert_core.sv =====
// ----------------------------------------------------------------------------
// top_score_table_insert_core: top-K score table with sorted insertion
// Query, insert and row read over a streaming interface.
// ----------------------------------------------------------------------------
// Query and insert walk the ranked rows from the bottom up; an insert that
// lands in row 0 also passes through S_LAST. A read fetches only its row.
// Throughput: one transaction at a time, set by the walk over the row memory
// at one row per cycle; the next is accepted the cycle after the result
// enters the output register. Reset clears the row valid bits, so the whole
// table reads as zero right after reset.
module top_score_table_insert_core #(
    parameter int RANKED_ROWS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // name_char0, name_char1, name_char2, new_extra, new_score, row_index
    input  logic [stic_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [stic_pkg::FUNC_W-1:0]     s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // name_free, inserted, insert_pos, row_name0, row_name1, row_name2,
    // row_extra, row_score
    output logic [stic_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(RANKED_ROWS + 1);

    stic_pkg::cmd_t    cmd;
    stic_pkg::status_t st;
    stic_pkg::res_t    out_res;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    stic_ctrl #(
        .RANKED_ROWS(RANKED_ROWS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    stic_dp #(
        .RANKED_ROWS(RANKED_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_func  (s_tuser),
        .req_name  (s_tdata[23:0]),
        .req_extra (s_tdata[55:24]),
        .req_score (s_tdata[87:56]),
        .req_index (s_tdata[91:88]),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .st        (st),
        .out_res   (out_res)
    );

    // result packing
    assign m_tdata = {2'b00,
                      out_res.row.score,
                      out_res.row.extra,
                      out_res.row.name,
                      out_res.pos,
                      out_res.inserted,
                      out_res.name_free};

    // one transaction in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // a result never both frees a name and reports an insert
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("name_free and inserted both set");

    // no insert means the position reads as the row count
    a_pos_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[5:2] == stic_pkg::POS_W'(RANKED_ROWS))
        else $error("insert_pos wrong for a result without insert");

endmodule
